>>> sv/assert_macros.svh
// Assertion macros used by the RTL of the frame decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SFD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define SFD_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define SFD_ASSERT(lbl, clk, rstn, prop, msg)
`define SFD_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> sv/sfd_pkg.sv
// Types and constants of the serial frame decoder.
`timescale 1ns / 1ps
package sfd_pkg;
  localparam int FRAME_LEN    = 25;
  localparam int NUM_CHANNELS = 16;
  localparam int ADDR_W       = $clog2(FRAME_LEN);
  localparam int CHAN_BITS    = 11;
  localparam int ACC_W        = CHAN_BITS + 7;
  localparam int CNT_W        = $clog2(ACC_W + 1);
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_IDX_LSB  = 2;

  localparam logic [7:0] SYNC_BYTE = 8'h0F;
  localparam logic [7:0] END_BYTE  = 8'h00;

  localparam logic [ADDR_W-1:0] FLAG_POS   = ADDR_W'(FRAME_LEN - 2);
  localparam logic [ADDR_W-1:0] FOOTER_POS = ADDR_W'(FRAME_LEN - 1);

  localparam logic [CHAN_BITS-1:0] OFFSET_RESET = 11'd1024;

  localparam logic [CFG_ADDR_W-CFG_IDX_LSB-1:0] REG_CHANNEL_OFFSET = '0;

  localparam int FLAG_CH17     = 0;
  localparam int FLAG_CH18     = 1;
  localparam int FLAG_LOST     = 2;
  localparam int FLAG_FAILSAFE = 3;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] count_t;

  typedef struct packed {
    logic [3:0]         channel_index;
    logic signed [11:0] channel_value;
    logic               digital_ch17;
    logic               digital_ch18;
    logic               lost_flag;
    logic               failsafe_flag;
    count_t             frame_number;
    logic               last_channel;
    count_t             lost_count;
    count_t             failsafe_count;
    count_t             bad_footer_count;
    count_t             resync_count;
  } res_t;
endpackage

>>> sv/sfd_byte_if.sv
// Input channel: one received serial byte per item.
`timescale 1ns / 1ps
interface sfd_byte_if;
  import sfd_pkg::*;
  logic  valid;
  logic  ready;
  byte_t rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> sv/sfd_res_if.sv
// Result channel: one decoded channel per item.
`timescale 1ns / 1ps
interface sfd_res_if;
  import sfd_pkg::*;
  logic               valid;
  logic               ready;
  logic [3:0]         channel_index;
  logic signed [11:0] channel_value;
  logic               digital_ch17;
  logic               digital_ch18;
  logic               lost_flag;
  logic               failsafe_flag;
  count_t             frame_number;
  logic               last_channel;
  count_t             lost_count;
  count_t             failsafe_count;
  count_t             bad_footer_count;
  count_t             resync_count;
  modport source (output valid, output channel_index, output channel_value,
                  output digital_ch17, output digital_ch18, output lost_flag,
                  output failsafe_flag, output frame_number, output last_channel,
                  output lost_count, output failsafe_count, output bad_footer_count,
                  output resync_count, input ready);
  modport sink (input valid, input channel_index, input channel_value,
                input digital_ch17, input digital_ch18, input lost_flag,
                input failsafe_flag, input frame_number, input last_channel,
                input lost_count, input failsafe_count, input bad_footer_count,
                input resync_count, output ready);
endinterface

>>> sv/sbus_frame_decoder_top.sv
// Frame decoder top level: byte collection, frame buffer memory and channel unpacking.
//
//   channel | direction | handshake         | payload
//   in_if   | in        | valid/ready       | rx_byte
//   out_if  | out       | valid/ready       | channel_index .. resync_count
//   apb     | in        | psel/penable      | offset register at byte 0
//
// A byte that does not complete a frame leaves the decoder ready for the next byte.
// On a good frame's footer byte the flags byte and the 22 channel bytes are read one at a time
// from the frame buffer, and the 16 results are unpacked from them in order.
// On a bad footer, one pass over the buffer finds the next header and moves it to the front.
// Input is held off while a frame is unpacked or moved; a stalled result holds the unpacker.
// Reset is synchronous; the buffer itself is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sbus_frame_decoder_top (
  input  logic                            clk,
  input  logic                            rst_n,
  sfd_byte_if.sink                        in_if,
  sfd_res_if.source                       out_if,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sfd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import sfd_pkg::*;

  typedef enum logic [2:0] {
    S_COLLECT,
    S_FLAGS,
    S_FLAGW,
    S_FILL,
    S_EMIT,
    S_SHIFT_RD,
    S_SHIFT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [ADDR_W-1:0]      fill_r, fill_nxt;
  logic [ADDR_W-1:0]      ptr_r, ptr_nxt;
  logic [ADDR_W-1:0]      dst_r, dst_nxt;
  logic                   found_r, found_nxt;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [3:0]             ch_r, ch_nxt;
  logic [3:0]             flags_r, flags_nxt;
  count_t                 valid_r, valid_nxt;
  count_t                 lost_r, lost_nxt;
  count_t                 fs_r, fs_nxt;
  count_t                 rej_r, rej_nxt;
  count_t                 resync_r, resync_nxt;
  logic [CHAN_BITS-1:0]   offset_r;
  res_t                   out_r, out_nxt;
  logic                   out_valid_r, out_valid_nxt;

  byte_t                  mem_r [FRAME_LEN];
  byte_t                  rd_data_r;
  logic                   mem_we, mem_re;
  logic [ADDR_W-1:0]      mem_wa, mem_ra;
  byte_t                  mem_wd;

  logic                   out_free;
  logic                   last_ch;
  logic [CNT_W-1:0]       cnt_left;
  logic                   cfg_hit;

  assign cfg_hit  = (paddr[CFG_ADDR_W-1:CFG_IDX_LSB] == REG_CHANNEL_OFFSET);
  assign pready   = 1'b1;
  assign prdata   = cfg_hit ? 32'(offset_r) : 32'd0;
  assign out_free = !out_valid_r || out_if.ready;
  assign last_ch  = (ch_r == 4'(NUM_CHANNELS - 1));
  assign cnt_left = cnt_r - CNT_W'(CHAN_BITS);
  assign in_if.ready = (state_r == S_COLLECT);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ptr_nxt       = ptr_r;
    dst_nxt       = dst_r;
    found_nxt     = found_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    ch_nxt        = ch_r;
    flags_nxt     = flags_r;
    valid_nxt     = valid_r;
    lost_nxt      = lost_r;
    fs_nxt        = fs_r;
    rej_nxt       = rej_r;
    resync_nxt    = resync_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = in_if.rx_byte;
    mem_re        = 1'b0;
    mem_ra        = '0;
    case (state_r)
      S_COLLECT: begin
        if (in_if.valid) begin
          if (fill_r == '0) begin
            if (in_if.rx_byte == SYNC_BYTE) begin
              mem_we   = 1'b1;
              fill_nxt = ADDR_W'(1);
            end
          end else if (32'(fill_r) >= FRAME_LEN) begin
            fill_nxt = '0;
          end else begin
            mem_we = 1'b1;
            mem_wa = fill_r;
            if (fill_r == FOOTER_POS) begin
              if (in_if.rx_byte == END_BYTE) begin
                fill_nxt  = '0;
                state_nxt = S_FLAGS;
              end else begin
                rej_nxt    = rej_r + 32'd1;
                resync_nxt = resync_r + 32'd1;
                state_nxt  = S_SHIFT_RD;
              end
            end else begin
              fill_nxt = fill_r + ADDR_W'(1);
            end
          end
        end
      end
      S_FLAGS: begin
        mem_re    = 1'b1;
        mem_ra    = FLAG_POS;
        state_nxt = S_FLAGW;
      end
      S_FLAGW: begin
        flags_nxt = rd_data_r[3:0];
        valid_nxt = valid_r + 32'd1;
        lost_nxt  = lost_r + 32'(rd_data_r[FLAG_LOST]);
        fs_nxt    = fs_r + 32'(rd_data_r[FLAG_FAILSAFE]);
        mem_re    = 1'b1;
        mem_ra    = ADDR_W'(1);
        ptr_nxt   = ADDR_W'(2);
        acc_nxt   = '0;
        cnt_nxt   = '0;
        ch_nxt    = '0;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        acc_nxt = acc_r | (ACC_W'(rd_data_r) << cnt_r);
        cnt_nxt = cnt_r + CNT_W'(8);
        if (cnt_nxt >= CNT_W'(CHAN_BITS)) begin
          state_nxt = S_EMIT;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = ptr_r;
          ptr_nxt = ptr_r + ADDR_W'(1);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_nxt.channel_index   = ch_r;
          out_nxt.channel_value   = {1'b0, acc_r[CHAN_BITS-1:0]} - {1'b0, offset_r};
          out_nxt.digital_ch17    = flags_r[FLAG_CH17];
          out_nxt.digital_ch18    = flags_r[FLAG_CH18];
          out_nxt.lost_flag       = flags_r[FLAG_LOST];
          out_nxt.failsafe_flag   = flags_r[FLAG_FAILSAFE];
          out_nxt.frame_number    = valid_r;
          out_nxt.last_channel    = last_ch;
          out_nxt.lost_count      = lost_r;
          out_nxt.failsafe_count  = fs_r;
          out_nxt.bad_footer_count = rej_r;
          out_nxt.resync_count    = resync_r;
          acc_nxt = acc_r >> CHAN_BITS;
          cnt_nxt = cnt_left;
          ch_nxt  = ch_r + 4'd1;
          if (last_ch) begin
            state_nxt = S_COLLECT;
          end else if (cnt_left < CNT_W'(CHAN_BITS)) begin
            mem_re    = 1'b1;
            mem_ra    = ptr_r;
            ptr_nxt   = ptr_r + ADDR_W'(1);
            state_nxt = S_FILL;
          end
        end
      end
      S_SHIFT_RD: begin
        mem_re    = 1'b1;
        mem_ra    = ADDR_W'(1);
        ptr_nxt   = ADDR_W'(2);
        found_nxt = 1'b0;
        dst_nxt   = '0;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        mem_wd = rd_data_r;
        if (found_r || rd_data_r == SYNC_BYTE) begin
          found_nxt = 1'b1;
          mem_we    = 1'b1;
          mem_wa    = dst_r;
          dst_nxt   = dst_r + ADDR_W'(1);
        end
        if (ptr_r - ADDR_W'(1) == FOOTER_POS) begin
          fill_nxt  = dst_nxt;
          state_nxt = S_COLLECT;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = ptr_r;
          ptr_nxt = ptr_r + ADDR_W'(1);
        end
      end
      default: begin
        state_nxt = S_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem_r[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_COLLECT;
      fill_r      <= '0;
      ptr_r       <= '0;
      dst_r       <= '0;
      found_r     <= 1'b0;
      cnt_r       <= '0;
      ch_r        <= '0;
      valid_r     <= '0;
      lost_r      <= '0;
      fs_r        <= '0;
      rej_r       <= '0;
      resync_r    <= '0;
      offset_r    <= OFFSET_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ptr_r       <= ptr_nxt;
      dst_r       <= dst_nxt;
      found_r     <= found_nxt;
      cnt_r       <= cnt_nxt;
      ch_r        <= ch_nxt;
      valid_r     <= valid_nxt;
      lost_r      <= lost_nxt;
      fs_r        <= fs_nxt;
      rej_r       <= rej_nxt;
      resync_r    <= resync_nxt;
      out_valid_r <= out_valid_nxt;
      if (psel && penable && pwrite && cfg_hit) begin
        offset_r <= pwdata[CHAN_BITS-1:0];
      end
    end
    acc_r   <= acc_nxt;
    flags_r <= flags_nxt;
    out_r   <= out_nxt;
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.channel_index    = out_r.channel_index;
  assign out_if.channel_value    = out_r.channel_value;
  assign out_if.digital_ch17     = out_r.digital_ch17;
  assign out_if.digital_ch18     = out_r.digital_ch18;
  assign out_if.lost_flag        = out_r.lost_flag;
  assign out_if.failsafe_flag    = out_r.failsafe_flag;
  assign out_if.frame_number     = out_r.frame_number;
  assign out_if.last_channel     = out_r.last_channel;
  assign out_if.lost_count       = out_r.lost_count;
  assign out_if.failsafe_count   = out_r.failsafe_count;
  assign out_if.bad_footer_count = out_r.bad_footer_count;
  assign out_if.resync_count     = out_r.resync_count;

  `SFD_ASSERT(a_emit_bits, clk, rst_n, state_r == S_EMIT |-> cnt_r >= CNT_W'(CHAN_BITS), "short")
  `SFD_ASSERT(a_fill_ptr, clk, rst_n, state_r == S_FILL |-> ptr_r <= FLAG_POS, "ptr past flags")
  `SFD_ASSERT(a_fill_bound, clk, rst_n, state_r == S_COLLECT |-> fill_r <= FOOTER_POS, "bad fill")
endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Frame decoder bench: random byte streams, an item-level predictor and an in-order result check.
module testbench;
  import sfd_pkg::*;

  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int REPORT_MAX   = 10;
  localparam int PHASES       = 5;
  localparam int MAX_IDLE     = 15;
  localparam int PHASE_BYTES  = 45;
  localparam logic [CFG_ADDR_W-CFG_IDX_LSB-1:0] REG_UNUSED = 1'b1;

  logic                  clk     = 1'b0;
  logic                  rst_n   = 1'b0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [31:0]           pwdata  = '0;
  logic [31:0]           prdata;
  logic                  pready;

  sfd_byte_if byte_ch ();
  sfd_res_if  res_ch ();

  sbus_frame_decoder_top uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (byte_ch),
    .out_if  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // decoder state as predicted
  byte_t                buf_bytes [FRAME_LEN];
  int                   buf_fill;
  count_t               good_frames;
  count_t               lost_total;
  count_t               failsafe_total;
  count_t               footer_rejects;
  count_t               resyncs;
  logic [CHAN_BITS-1:0] offset_reg;

  byte_t pending_bytes[$];
  res_t  expected_channels[$];

  int in_gap_max    = 0;
  int out_stall_max = 0;
  bit out_hold      = 1'b0;
  bit byte_taken    = 1'b0;
  bit res_taken     = 1'b0;
  int send_wait     = 0;
  int recv_wait     = 0;
  int quiet_cycles  = 0;
  int mismatch_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void absorb_byte(input byte_t b);
    logic [8*(FRAME_LEN-1)-1:0] bits;
    logic [CHAN_BITS-1:0]       raw;
    byte_t                      flags;
    int                         pos;
    res_t                       r;
    if (buf_fill == 0) begin
      if (b == SYNC_BYTE) begin
        buf_bytes[0] = b;
        buf_fill = 1;
      end
      return;
    end
    buf_bytes[buf_fill] = b;
    buf_fill++;
    if (buf_fill != FRAME_LEN) return;
    if (buf_bytes[FRAME_LEN-1] == END_BYTE) begin
      buf_fill = 0;
      flags = buf_bytes[FRAME_LEN-2];
      good_frames++;
      if (flags[FLAG_LOST]) lost_total++;
      if (flags[FLAG_FAILSAFE]) failsafe_total++;
      for (int i = 1; i < FRAME_LEN; i++) bits[8*(i-1) +: 8] = buf_bytes[i];
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        raw = bits[CHAN_BITS*k +: CHAN_BITS];
        r.channel_index    = 4'(k);
        r.channel_value    = {1'b0, raw} - {1'b0, offset_reg};
        r.digital_ch17     = flags[FLAG_CH17];
        r.digital_ch18     = flags[FLAG_CH18];
        r.lost_flag        = flags[FLAG_LOST];
        r.failsafe_flag    = flags[FLAG_FAILSAFE];
        r.frame_number     = good_frames;
        r.last_channel     = (k == NUM_CHANNELS - 1);
        r.lost_count       = lost_total;
        r.failsafe_count   = failsafe_total;
        r.bad_footer_count = footer_rejects;
        r.resync_count     = resyncs;
        expected_channels.push_back(r);
      end
      return;
    end
    footer_rejects++;
    resyncs++;
    pos = FRAME_LEN;
    for (int i = 1; i < FRAME_LEN; i++) begin
      if (pos == FRAME_LEN && buf_bytes[i] == SYNC_BYTE) pos = i;
    end
    if (pos == FRAME_LEN) begin
      buf_fill = 0;
    end else begin
      for (int i = 0; i < FRAME_LEN - pos; i++) buf_bytes[i] = buf_bytes[i+pos];
      buf_fill = FRAME_LEN - pos;
    end
  endfunction

  function automatic string describe(input res_t r);
    return $sformatf("ch=%0d val=%0d flags=%b%b%b%b frame=%0d last=%b lost=%0d fs=%0d %s",
                     r.channel_index, r.channel_value, r.failsafe_flag, r.lost_flag,
                     r.digital_ch18, r.digital_ch17, r.frame_number, r.last_channel,
                     r.lost_count, r.failsafe_count,
                     $sformatf("badftr=%0d resync=%0d", r.bad_footer_count, r.resync_count));
  endfunction

  function automatic void check_channel();
    res_t got;
    res_t want;
    got.channel_index    = res_ch.channel_index;
    got.channel_value    = res_ch.channel_value;
    got.digital_ch17     = res_ch.digital_ch17;
    got.digital_ch18     = res_ch.digital_ch18;
    got.lost_flag        = res_ch.lost_flag;
    got.failsafe_flag    = res_ch.failsafe_flag;
    got.frame_number     = res_ch.frame_number;
    got.last_channel     = res_ch.last_channel;
    got.lost_count       = res_ch.lost_count;
    got.failsafe_count   = res_ch.failsafe_count;
    got.bad_footer_count = res_ch.bad_footer_count;
    got.resync_count     = res_ch.resync_count;
    if (expected_channels.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) $display("unexpected result: %s", describe(got));
      return;
    end
    want = expected_channels.pop_front();
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) begin
        $display("mismatch: expected %s", describe(want));
        $display("          actual   %s", describe(got));
      end
    end
  endfunction

  always @(posedge clk) begin
    byte_taken = rst_n && ((byte_ch.valid & byte_ch.ready) === 1'b1);
    res_taken  = rst_n && ((res_ch.valid & res_ch.ready) === 1'b1);
    if (res_taken) check_channel();
    if (byte_taken) absorb_byte(byte_ch.rx_byte);
    if (byte_taken || res_taken || (psel && penable && pwrite && pready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      byte_ch.valid <= 1'b0;
    end else if (!byte_ch.valid || byte_taken) begin
      if (send_wait > 0) begin
        byte_ch.valid <= 1'b0;
        send_wait--;
      end else if (pending_bytes.size() != 0) begin
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= pending_bytes.pop_front();
        send_wait = $urandom_range(0, in_gap_max);
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (res_taken) recv_wait = $urandom_range(0, out_stall_max);
    if (!rst_n || out_hold) begin
      res_ch.ready <= 1'b0;
    end else if (recv_wait > 0) begin
      res_ch.ready <= 1'b0;
      recv_wait--;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  function automatic void queue_frame(input bit random_fill, input byte_t fill,
                                      input byte_t flags, input byte_t footer,
                                      input int sync_pct);
    byte_t b;
    pending_bytes.push_back(SYNC_BYTE);
    for (int i = 1; i < FRAME_LEN - 2; i++) begin
      b = random_fill ? byte_t'($urandom()) : fill;
      if ($urandom_range(1, 100) <= sync_pct) b = SYNC_BYTE;
      pending_bytes.push_back(b);
    end
    pending_bytes.push_back(flags);
    pending_bytes.push_back(footer);
  endfunction

  function automatic void queue_stream(input int target);
    int queued;
    int kind;
    int n;
    queued = 0;
    while (queued < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        queue_frame(1'b1, '0, byte_t'($urandom()), END_BYTE, 3);
        queued += FRAME_LEN;
      end else if (kind < 82) begin
        queue_frame(1'b1, '0, byte_t'($urandom()), byte_t'($urandom_range(1, 255)), 10);
        queued += FRAME_LEN;
      end else if (kind < 90) begin
        n = $urandom_range(1, FRAME_LEN - 2);
        pending_bytes.push_back(SYNC_BYTE);
        repeat (n) pending_bytes.push_back(byte_t'($urandom()));
        queued += n + 1;
      end else begin
        repeat ($urandom_range(1, 4)) pending_bytes.push_back(byte_t'($urandom()));
      end
    end
  endfunction

  task automatic cfg_write(input logic [CFG_ADDR_W-CFG_IDX_LSB-1:0] idx,
                           input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, {CFG_IDX_LSB{1'b0}}};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_CHANNEL_OFFSET) offset_reg = data[CHAN_BITS-1:0];
    @(posedge clk);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || byte_ch.valid || expected_channels.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [CHAN_BITS-1:0] next_offset;
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = '0;
    res_ch.ready    = 1'b0;
    offset_reg      = OFFSET_RESET;
    buf_fill        = 0;
    good_frames     = '0;
    lost_total      = '0;
    failsafe_total  = '0;
    footer_rejects  = '0;
    resyncs         = '0;
    for (int i = 0; i < FRAME_LEN; i++) buf_bytes[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_gap_max    = MAX_IDLE;
    out_stall_max = MAX_IDLE;
    // drop bytes while empty, then max channels, footer rejects and a partial frame
    pending_bytes = '{8'h00, 8'hFF, 8'hF0, 8'h0E};
    queue_frame(1'b0, 8'hFF, 8'h0F, END_BYTE, 0);
    queue_frame(1'b0, 8'hA5, 8'hF0, 8'hFF, 0);
    queue_frame(1'b0, SYNC_BYTE, 8'h05, 8'h80, 0);
    pending_bytes.push_back(SYNC_BYTE);
    repeat (3) pending_bytes.push_back(8'h55);
    queue_frame(1'b1, '0, 8'h0A, END_BYTE, 0);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 1) cfg_write(REG_UNUSED, $urandom());
      if (p > 0) begin
        next_offset = (p == 1) ? '0 : (p == 2) ? '1 : CHAN_BITS'($urandom_range(0, 2047));
        cfg_write(REG_CHANNEL_OFFSET, {21'($urandom()), next_offset});
      end
      in_gap_max    = (p % 2 == 0) ? MAX_IDLE : 0;
      out_stall_max = (p == 1 || p == 2) ? 0 : MAX_IDLE;
      if (p == 1 || p == 2) begin
        queue_frame(1'b0, 8'hFF, byte_t'($urandom()), END_BYTE, 0);
        queue_frame(1'b0, 8'h00, byte_t'($urandom()), END_BYTE, 0);
      end
      queue_stream(PHASE_BYTES);
      if (p == 1) begin
        // hold results off while bytes keep coming
        out_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_hold = 1'b0;
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
